/* design/brb_pkg.sv */
`timescale 1ns / 1ps
package brb_pkg;

  // Field widths of the stream words
  localparam int CAP_W     = 13;
  localparam int BYTE_W    = 8;
  localparam int RLEN_W    = 7;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  // Input word layout (tdata), lowest bit first
  localparam int IN_FIRST_LSB = 0;
  localparam int IN_BLEN_LSB  = 1;
  localparam int IN_DIN_LSB   = IN_BLEN_LSB + CAP_W;
  localparam int IN_RLEN_LSB  = IN_DIN_LSB + BYTE_W;

  // Defaults
  localparam int DEPTH_DEFAULT    = 4096;
  localparam int READ_MAX_DEFAULT = 64;
  localparam int CAP_DEFAULT      = 4096;

  // Item kinds on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Result status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic cfg_load;   // take a capacity write, empty the FIFO
    logic item_load;  // take one input word
    logic rd_fetch;   // issue the first storage read of a request
    logic rd_send;    // emit one read byte, prefetch the next
  } brb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;  // output register can take a word this cycle
    logic rd_none;    // incoming read request delivers no byte
    logic rd_final;   // byte in flight is the last of its request
  } brb_sts_t;

endpackage

/* design/brb_ram.sv */
`timescale 1ns / 1ps
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/brb_ctrl.sv */
`timescale 1ns / 1ps
module brb_ctrl
  import brb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tuser,
  input  logic     cfg_valid,
  input  brb_sts_t sts,
  output logic     s_tready,
  output brb_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } state_t;

  state_t state, state_next;

  // Accept a word only when idle and the result has a place to go
  assign s_tready = (state == S_IDLE) && sts.slot_free;

  always_comb begin
    state_next    = state;
    cmd.cfg_load  = cfg_valid;
    cmd.item_load = 1'b0;
    cmd.rd_fetch  = 1'b0;
    cmd.rd_send   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && sts.slot_free) begin
          cmd.item_load = 1'b1;
          if (s_tuser == FUNC_READ && !sts.rd_none) begin
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_fetch = 1'b1;
        state_next   = S_SEND;
      end
      S_SEND: begin
        if (sts.slot_free) begin
          cmd.rd_send = 1'b1;
          if (sts.rd_final) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state, drop back to idle on a capacity write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (cfg_valid) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/brb_dp.sv */
`timescale 1ns / 1ps
module brb_dp
  import brb_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEFAULT,
  parameter int READ_MAX = READ_MAX_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  brb_cmd_t              cmd,
  output brb_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic [CAP_W-1:0]      cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
  localparam int RW    = $clog2(READ_MAX + 1);
  localparam int CAP_MAXV  = (1 << CAP_W) - 1;
  localparam int DEPTH_CAP = (DEPTH > CAP_MAXV) ? CAP_MAXV : DEPTH;
  localparam int CAP_RESET = (CAP_DEFAULT > DEPTH_CAP) ? DEPTH_CAP : CAP_DEFAULT;

  // State
  logic [CAP_W-1:0] cap;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic [CAP_W-1:0] fill, fill_next;
  logic             b_acc;
  logic [CAP_W-1:0] b_rem, b_total;
  logic [RW-1:0]    rd_left, rd_total;

  // Output register
  logic             out_valid;
  logic             out_kind, out_status, out_last;
  logic [BYTE_W-1:0] out_data;
  logic [CAP_W-1:0] out_count, out_fill;

  // Input fields
  logic              func, first;
  logic [CAP_W-1:0]  blen;
  logic [BYTE_W-1:0] din;
  logic [RLEN_W-1:0] rlen;

  assign func  = s_tuser;
  assign first = s_tdata[IN_FIRST_LSB];
  assign blen  = s_tdata[IN_BLEN_LSB +: CAP_W];
  assign din   = s_tdata[IN_DIN_LSB +: BYTE_W];
  assign rlen  = s_tdata[IN_RLEN_LSB +: RLEN_W];

  // Burst admission and write decision
  logic             fits, cont_ok, wr_store, wr_status;
  logic [CAP_W-1:0] wr_count;

  assign fits     = blen <= (cap - fill);
  assign cont_ok  = b_acc && (b_rem != '0) && (fill < cap);
  assign wr_store = cmd.item_load && (func == FUNC_WRITE) &&
                    (first ? (fits && blen != '0) : cont_ok);
  assign wr_status = (first ? fits : cont_ok) ? ST_OK : ST_REJECT;
  assign wr_count  = first ? (fits ? blen : '0) : (cont_ok ? b_total : '0);

  // Read length: clamp to READ_MAX and to the fill
  logic [RLEN_W-1:0] rq;
  logic [RW-1:0]     rd_n;

  assign rq   = (rlen > RLEN_W'(READ_MAX)) ? RLEN_W'(READ_MAX) : rlen;
  assign rd_n = (CAP_W'(rq) > fill) ? fill[RW-1:0] : rq[RW-1:0];

  // Load a result word at acceptance for every write and for an empty read
  logic res_load;

  assign res_load = cmd.item_load && ((func == FUNC_WRITE) || (rd_n == '0));

  // Index advance with wrap at the capacity
  logic [CW-1:0]    wr_inc, rd_inc;
  logic [IDX_W-1:0] wr_idx_adv, rd_idx_adv;

  assign wr_inc     = CW'(wr_idx) + CW'(1);
  assign rd_inc     = CW'(rd_idx) + CW'(1);
  assign wr_idx_adv = (wr_inc >= CW'(cap)) ? '0 : wr_inc[IDX_W-1:0];
  assign rd_idx_adv = (rd_inc >= CW'(cap)) ? '0 : rd_inc[IDX_W-1:0];

  // Status to controller
  assign sts.slot_free = !out_valid || m_tready;
  assign sts.rd_none   = (rd_n == '0);
  assign sts.rd_final  = (rd_left == RW'(1));

  // Fill update
  always_comb begin
    fill_next = fill;
    if (wr_store) begin
      fill_next = fill + CAP_W'(1);
    end else if (cmd.rd_send) begin
      fill_next = fill - CAP_W'(1);
    end
  end

  // Clamped capacity from a config write
  logic [CAP_W-1:0] cap_new;

  always_comb begin
    if (cfg_data == '0) begin
      cap_new = CAP_W'(1);
    end else if (cfg_data > CAP_W'(DEPTH_CAP)) begin
      cap_new = CAP_W'(DEPTH_CAP);
    end else begin
      cap_new = cfg_data;
    end
  end

  // Storage
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign ram_re    = cmd.rd_fetch || (cmd.rd_send && !sts.rd_final);
  assign ram_raddr = cmd.rd_fetch ? rd_idx : rd_idx_adv;

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_store),
    .waddr (wr_idx),
    .wdata (din),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // FIFO and burst state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap      <= CAP_W'(CAP_RESET);
      wr_idx   <= '0;
      rd_idx   <= '0;
      fill     <= '0;
      b_acc    <= 1'b0;
      b_rem    <= '0;
      b_total  <= '0;
      rd_left  <= '0;
      rd_total <= '0;
    end else if (cmd.cfg_load) begin
      cap      <= cap_new;
      wr_idx   <= '0;
      rd_idx   <= '0;
      fill     <= '0;
      b_acc    <= 1'b0;
      b_rem    <= '0;
      b_total  <= '0;
      rd_left  <= '0;
    end else begin
      fill <= fill_next;
      if (cmd.item_load && func == FUNC_WRITE) begin
        if (first) begin
          b_acc   <= fits;
          b_total <= fits ? blen : '0;
          b_rem   <= (fits && blen != '0) ? blen - CAP_W'(1) : '0;
        end else if (cont_ok) begin
          b_rem <= b_rem - CAP_W'(1);
        end
      end
      if (wr_store) begin
        wr_idx <= wr_idx_adv;
      end
      if (cmd.item_load && func == FUNC_READ) begin
        rd_left  <= rd_n;
        rd_total <= rd_n;
      end
      if (cmd.rd_send) begin
        rd_idx  <= rd_idx_adv;
        rd_left <= rd_left - RW'(1);
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load || cmd.rd_send) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_send) begin
      out_kind   <= FUNC_READ;
      out_status <= ST_OK;
      out_data   <= ram_rdata;
      out_count  <= CAP_W'(rd_total);
      out_last   <= sts.rd_final;
      out_fill   <= fill_next;
    end else if (res_load) begin
      out_kind   <= func;
      out_status <= (func == FUNC_WRITE) ? wr_status : ST_OK;
      out_data   <= '0;
      out_count  <= (func == FUNC_WRITE) ? wr_count : '0;
      out_last   <= 1'b1;
      out_fill   <= fill_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_DATA_W'({out_fill, out_count, out_data, out_status});

endmodule

/* design/byte_ring_buffer_bursts.sv */
`timescale 1ns / 1ps
// Circular byte FIFO with burst writes and bounded read requests.
// Input stream: tuser selects a write byte (0) or a read request (1).
//   A write byte returns one status word: accept/reject, burst length and
//   fill level. The first byte of a burst carries its length; the whole
//   burst is rejected if it does not fit the capacity or the free space.
//   A read request returns min(request, READ_MAX, fill) data words with
//   tlast on the final one, or a single empty word when nothing is stored or no byte is asked for.
// Output stream: tuser is the result kind (0 status, 1 read data).
// Config channel: writes the capacity (1..DEPTH) and empties the FIFO.
// Timing: a write or an empty read loads its result at acceptance; the
//   result shows the next cycle. A read spends the cycle after its
//   acceptance on the first storage read, then loads one byte per cycle
//   while the receiver keeps the output register drained. The next
//   input word is taken once the last result of the previous one sits in
//   the output register and that register is being drained or empty.
// Reset empties the FIFO and sets the capacity to 4096 (or DEPTH if less);
//   no clearing pass is run. A stalled receiver holds the output word and
//   the block stops taking input until it is drained.
module byte_ring_buffer_bursts
  import brb_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEFAULT,
  parameter int READ_MAX = READ_MAX_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // burst_first[0], burst_length[13:1], data_in[21:14], read_length[28:22]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[0], data_out[8:1], byte_count[21:9], fill_level[34:22]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kind[0]
  output logic                  m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data
);

  brb_cmd_t cmd;
  brb_sts_t sts;

  assign cfg_ready = 1'b1;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .s_tready  (s_tready),
    .cmd       (cmd)
  );

  brb_dp #(
    .DEPTH    (DEPTH),
    .READ_MAX (READ_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Input is taken only when the output register has room
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input taken while output register is full");

  // A read run in progress blocks new input
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && !m_tlast) |-> !s_tready)
    else $error("input accepted in the middle of a read run");

  // A read word without tlast belongs to a nonempty request
  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && !m_tlast) |-> (m_tdata[21:9] != '0))
    else $error("read data word with zero byte count");

endmodule
